### sv/tmva_pkg.sv
// ----------------------------------------------------------------------------
// tmva_pkg
// Shared types, codes and sizes for the threshold max-value accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmva_pkg;

    // Table size and derived widths
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int KEY_W = 20;
    localparam int VAL_W = 20;
    localparam int SUM_W = 48;

    // Action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key_or_ability;
        logic [VAL_W-1:0] job_value;
    } cmd_t;

    // Result word
    typedef struct packed {
        logic [VAL_W-1:0] best_value;
        logic [SUM_W-1:0] running_total;
    } res_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // RAM write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    // RAM read request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### sv/threshold_max_value_accumulator.sv
// ----------------------------------------------------------------------------
// threshold_max_value_accumulator
// Table of (key, value) pairs answering "best value with key <= ability".
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one word per item:
//   load a pair, query with an ability, or clear table and total.
//   res channel (res_valid / res_stall / res) returns one word per query:
//   the best value and the saturating running total.
//   Load and clear are done on accept; cmd_stall stays low after them.
//   A query scans the stored entries one per cycle through the table RAM
//   read port and the single compare unit, at most TABLE_DEPTH of them;
//   the sequencer then passes DRAIN and DONE, and the result enters the
//   output register (an empty table goes straight to DONE). cmd_stall is
//   high in SCAN, DRAIN and DONE, so no new item is taken while a query runs.
//   The output register lets the next item be taken while a result waits;
//   if res_stall holds and a second query finishes, the sequencer waits
//   with cmd_stall high until the register frees up.
//   Reset empties the table (fill count to zero), zeroes the total and
//   drops any pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module threshold_max_value_accumulator (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire tmva_pkg::cmd_t cmd,
    output logic                res_valid,
    input  wire logic           res_stall,
    output tmva_pkg::res_t      res
);

    tmva_pkg::mem_wr_t  mem_wr;
    tmva_pkg::mem_rd_t  mem_rd;
    tmva_pkg::entry_t   rd_entry;
    logic [tmva_pkg::ENTRY_W-1:0] rd_data;
    logic               busy;
    logic               done_valid;
    tmva_pkg::res_t     done_word;
    logic               done_take;

    logic               res_valid_reg, res_valid_next;
    tmva_pkg::res_t     res_reg, res_next;

    assign cmd_stall = busy;
    assign rd_entry  = tmva_pkg::entry_t'(rd_data);

    tmva_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .busy       (busy),
        .mem_wr     (mem_wr),
        .mem_rd     (mem_rd),
        .rd_entry   (rd_entry),
        .done_valid (done_valid),
        .done_word  (done_word),
        .done_take  (done_take)
    );

    tmva_ram #(
        .DEPTH (tmva_pkg::TABLE_DEPTH),
        .WIDTH (tmva_pkg::ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr.en),
        .wr_addr (mem_wr.addr),
        .wr_data (mem_wr.data),
        .rd_en   (mem_rd.en),
        .rd_addr (mem_rd.addr),
        .rd_data (rd_data)
    );

    // Output register: free when empty or being drained this cycle
    assign done_take = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (done_take)
        begin
            res_valid_next = done_valid;
            if (done_valid)
            begin
                res_next = done_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### sv/tmva_ram.sv
// ----------------------------------------------------------------------------
// tmva_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmva_ram #(
    parameter  int DEPTH = 1024,
    parameter  int WIDTH = 40,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/tmva_ctrl.sv
// ----------------------------------------------------------------------------
// tmva_ctrl
// Sequencer with one shared compare unit: loads and clears entries, scans the
// table one entry per cycle for a query and keeps the saturating total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmva_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cmd_valid,
    input  wire tmva_pkg::cmd_t          cmd,
    output logic                         busy,
    output tmva_pkg::mem_wr_t            mem_wr,
    output tmva_pkg::mem_rd_t            mem_rd,
    input  wire tmva_pkg::entry_t        rd_entry,
    output logic                         done_valid,
    output tmva_pkg::res_t               done_word,
    input  wire logic                    done_take
);

    tmva_pkg::state_t                   state_reg, state_next;
    logic [tmva_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [tmva_pkg::ADDR_W-1:0]        idx_reg, idx_next;
    logic                               pend_reg, pend_next;
    logic [tmva_pkg::KEY_W-1:0]         ability_reg, ability_next;
    logic [tmva_pkg::VAL_W-1:0]         best_reg, best_next;
    logic [tmva_pkg::SUM_W-1:0]         sum_reg, sum_next;

    logic                               accept;
    logic                               table_full;
    logic                               last_idx;
    logic                               hit;
    logic [tmva_pkg::SUM_W:0]           sum_add;
    logic [tmva_pkg::SUM_W-1:0]         sum_sat;

    assign accept     = cmd_valid && (state_reg == tmva_pkg::ST_IDLE);
    assign table_full = (count_reg >= tmva_pkg::CNT_W'(tmva_pkg::TABLE_DEPTH));
    assign last_idx   = (tmva_pkg::CNT_W'(idx_reg) == (count_reg - tmva_pkg::CNT_W'(1)));

    // Shared compare unit: entry qualifies and beats the best so far
    assign hit = (rd_entry.key <= ability_reg) && (rd_entry.value > best_reg);

    // Saturating accumulate of the final answer
    assign sum_add = {1'b0, sum_reg} + (tmva_pkg::SUM_W+1)'(best_reg);
    assign sum_sat = sum_add[tmva_pkg::SUM_W] ? {tmva_pkg::SUM_W{1'b1}}
                                               : sum_add[tmva_pkg::SUM_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmva_pkg::ST_IDLE:
            begin
                if (accept && (cmd.action == tmva_pkg::ACT_QUERY))
                begin
                    state_next = (count_reg == '0) ? tmva_pkg::ST_DONE
                                                   : tmva_pkg::ST_SCAN;
                end
            end
            tmva_pkg::ST_SCAN:
            begin
                if (last_idx)
                begin
                    state_next = tmva_pkg::ST_DRAIN;
                end
            end
            tmva_pkg::ST_DRAIN:
            begin
                state_next = tmva_pkg::ST_DONE;
            end
            tmva_pkg::ST_DONE:
            begin
                if (done_take)
                begin
                    state_next = tmva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmva_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy          = (state_reg != tmva_pkg::ST_IDLE);
        mem_wr.en     = accept && (cmd.action == tmva_pkg::ACT_LOAD) && !table_full;
        mem_wr.addr   = count_reg[tmva_pkg::ADDR_W-1:0];
        mem_wr.data.key   = cmd.key_or_ability;
        mem_wr.data.value = cmd.job_value;
        mem_rd.en     = (state_reg == tmva_pkg::ST_SCAN);
        mem_rd.addr   = idx_reg;
        done_valid    = (state_reg == tmva_pkg::ST_DONE);
        done_word.best_value    = best_reg;
        done_word.running_total = sum_sat;
    end

    // Datapath next values
    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        pend_next    = (state_reg == tmva_pkg::ST_SCAN);
        ability_next = ability_reg;
        best_next    = best_reg;
        sum_next     = sum_reg;

        if (accept)
        begin
            case (cmd.action)
                tmva_pkg::ACT_LOAD:
                begin
                    if (!table_full)
                    begin
                        count_next = count_reg + tmva_pkg::CNT_W'(1);
                    end
                end
                tmva_pkg::ACT_QUERY:
                begin
                    ability_next = cmd.key_or_ability;
                    best_next    = '0;
                    idx_next     = '0;
                end
                tmva_pkg::ACT_CLEAR:
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        // Step the read address
        if (state_reg == tmva_pkg::ST_SCAN)
        begin
            idx_next = idx_reg + tmva_pkg::ADDR_W'(1);
        end

        // Compare the entry read last cycle
        if (pend_reg && hit)
        begin
            best_next = rd_entry.value;
        end

        // Commit the total when the result leaves
        if ((state_reg == tmva_pkg::ST_DONE) && done_take)
        begin
            sum_next = sum_sat;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmva_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            sum_reg   <= sum_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ability_reg <= ability_next;
        best_reg    <= best_next;
    end

endmodule

`default_nettype wire
